### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;
  localparam int DEPTH     = 16;
  localparam int TAG_BITS  = 32;
  localparam int PRIO_BITS = 16;
  localparam int KIND_BITS = 2;

  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SEARCH = 2'd2;

  // One stored entry, as held by a cell and passed between neighbors.
  typedef struct packed {
    logic                 valid;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } ctrl_t;
endpackage
`default_nettype wire

### rtl/spq_cell.sv
// One storage cell of the sorted chain: holds an entry, shifts with neighbors.
`default_nettype none
module spq_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  spq_pkg::ctrl_t       ctrl,
  input  spq_pkg::entry_t      left_entry,
  input  wire                  left_open,
  input  spq_pkg::entry_t      right_entry,
  output spq_pkg::entry_t      entry,
  output logic                 open,
  output logic                 match
);
  logic                          stored_valid;
  logic [spq_pkg::PRIO_BITS-1:0] stored_prio;
  logic [spq_pkg::TAG_BITS-1:0]  stored_tag;

  assign entry = '{valid: stored_valid, prio: stored_prio, tag: stored_tag};

  // open: new item belongs at or before this cell (empty or lower priority).
  assign open  = !stored_valid || (stored_prio < ctrl.prio);
  assign match = stored_valid && (stored_tag == ctrl.tag);

  always_ff @(posedge clk) begin
    if (ctrl.ins && open) begin
      if (left_open) begin
        stored_prio <= left_entry.prio;
        stored_tag  <= left_entry.tag;
      end else begin
        stored_prio <= ctrl.prio;
        stored_tag  <= ctrl.tag;
      end
    end else if (ctrl.rem) begin
      stored_prio <= right_entry.prio;
      stored_tag  <= right_entry.tag;
    end
  end

  // An empty neighbor shifting in keeps this cell empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_valid <= 1'b0;
    end else if (ctrl.ins && open) begin
      stored_valid <= left_open ? left_entry.valid : 1'b1;
    end else if (ctrl.rem) begin
      stored_valid <= right_entry.valid;
    end
  end
endmodule
`default_nettype wire

### rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: cell chain plus result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item: kind
//   selects insert, remove-highest or search, with item_tag and item_priority.
//   Output channel (out_valid/out_ready) returns exactly one result per item.
//   Entries live in a chain of DEPTH cells kept sorted by descending priority;
//   equal priorities keep arrival order. Every cell compares its priority
//   with the incoming one in parallel and shifts toward its neighbor, so an
//   insert, remove or search finishes in the cycle it is accepted.
//   Result: registered, valid the cycle after acceptance.
//   Throughput: one item per cycle while out_ready stays high; set by the cell update.
//   Stall: a held result blocks new items only while out_ready is low and the
//   result register is full; in_ready = !out_valid || out_ready.
//   Reset: rst (synchronous) empties the queue and drops any pending result.
//   Insert into a full queue sets dropped; remove on empty sets was_empty;
//   kind 3 returns an all-zero result and changes nothing.
`default_nettype none
module sorted_priority_queue_core (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [spq_pkg::KIND_BITS-1:0]   kind,
  input  wire [spq_pkg::TAG_BITS-1:0]    item_tag,
  input  wire [spq_pkg::PRIO_BITS-1:0]   item_priority,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [spq_pkg::TAG_BITS-1:0]   out_tag,
  output logic [spq_pkg::PRIO_BITS-1:0]  out_priority,
  output logic                           was_empty,
  output logic                           found,
  output logic                           dropped
);
  spq_pkg::entry_t               cells [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]     cell_open;
  logic [spq_pkg::DEPTH-1:0]     cell_match;
  logic [spq_pkg::DEPTH-1:0]     cell_valid;
  spq_pkg::ctrl_t                ctrl;
  logic                          accept;
  logic                          full;
  logic                          empty;
  logic                          is_ins;
  logic                          is_rem;
  logic                          is_srch;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Entries fill from cell 0, so the ends of the chain give empty and full.
  assign empty = !cells[0].valid;
  assign full  = cells[spq_pkg::DEPTH-1].valid;

  assign is_ins  = (kind == spq_pkg::KIND_INSERT);
  assign is_rem  = (kind == spq_pkg::KIND_REMOVE);
  assign is_srch = (kind == spq_pkg::KIND_SEARCH);

  // Broadcast to every cell; a refused insert or an empty remove is a no-op.
  assign ctrl.ins  = accept && is_ins && !full;
  assign ctrl.rem  = accept && is_rem && !empty;
  assign ctrl.prio = item_priority;
  assign ctrl.tag  = item_tag;

  genvar gi;
  generate
    for (gi = 0; gi < spq_pkg::DEPTH; gi++) begin : g_cell
      spq_pkg::entry_t left_e;
      spq_pkg::entry_t right_e;
      logic            left_o;

      if (gi == 0) begin : g_head
        // Nothing sits ahead of the head cell.
        assign left_e = '0;
        assign left_o = 1'b0;
      end else begin : g_mid
        assign left_e = cells[gi-1];
        assign left_o = cell_open[gi-1];
      end

      if (gi == spq_pkg::DEPTH - 1) begin : g_tail
        // Removing shifts an empty entry into the tail.
        assign right_e = '0;
      end else begin : g_body
        assign right_e = cells[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_entry  (left_e),
        .left_open   (left_o),
        .right_entry (right_e),
        .entry       (cells[gi]),
        .open        (cell_open[gi]),
        .match       (cell_match[gi])
      );
      assign cell_valid[gi] = cells[gi].valid;
    end
  endgenerate

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tag      <= (is_rem && !empty) ? cells[0].tag  : '0;
      out_priority <= (is_rem && !empty) ? cells[0].prio : '0;
      was_empty    <= is_rem && empty;
      found        <= is_srch && (|cell_match);
      dropped      <= is_ins && full;
    end
  end

  // Occupied cells always form a contiguous run starting at the head.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + spq_pkg::DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the head");

  // The head never holds a lower priority than its successor.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    cells[1].valid |-> (cells[0].prio >= cells[1].prio))
    else $error("queue order broken at the head");

  // A remove accepted on an empty queue reports empty next cycle.
  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (accept && is_rem && empty) |=> (out_valid && was_empty && out_tag == '0))
    else $error("empty remove not reported");

  // An insert accepted on a full queue is flagged and leaves the queue full.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && is_ins && full) |=> (dropped && full))
    else $error("insert into full queue not dropped");
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the sorted priority queue core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  // kind 3 has no name in the package; it is a no-op that returns all zeros
  localparam logic [KIND_BITS-1:0] KIND_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 900;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
    logic                 empty;
    logic                 hit;
    logic                 drop;
  } queue_result_t;

  // one line of the directed script
  typedef struct {
    logic [KIND_BITS-1:0] op;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
    bit                   typed;
    queue_result_t        want;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_BITS-1:0] kind = KIND_INSERT;
  logic [TAG_BITS-1:0]  item_tag = '0;
  logic [PRIO_BITS-1:0] item_priority = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TAG_BITS-1:0]  out_tag;
  logic [PRIO_BITS-1:0] out_priority;
  logic                 was_empty;
  logic                 found;
  logic                 dropped;

  // no random idling on either side while this is set
  logic steady = 1'b0;

  // shadow copy of the queue contents, head at index 0
  logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
  logic [TAG_BITS-1:0]  shadow_tag  [DEPTH];
  int                   shadow_count = 0;

  queue_result_t pending_results [$];
  queue_result_t got_result;
  queue_result_t want_result;
  int            mismatches = 0;
  int            results_seen = 0;

  sorted_priority_queue_core uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .item_tag      (item_tag),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tag       (out_tag),
    .out_priority  (out_priority),
    .was_empty     (was_empty),
    .found         (found),
    .dropped       (dropped)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow queue and return the result it gives.
  // Inserts land behind every entry of higher or equal priority, so ties
  // leave in arrival order.
  function automatic queue_result_t apply_queue_op(logic [KIND_BITS-1:0] op,
                                                   logic [TAG_BITS-1:0] tag,
                                                   logic [PRIO_BITS-1:0] prio);
    queue_result_t r;
    int pos;
    r = '0;
    case (op)
      KIND_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.drop = 1'b1;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_prio[i] = shadow_prio[i-1];
            shadow_tag[i]  = shadow_tag[i-1];
          end
          shadow_prio[pos] = prio;
          shadow_tag[pos]  = tag;
          shadow_count++;
        end
      end
      KIND_REMOVE: begin
        if (shadow_count == 0) begin
          r.empty = 1'b1;
        end else begin
          r.tag  = shadow_tag[0];
          r.prio = shadow_prio[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_prio[i-1] = shadow_prio[i];
            shadow_tag[i-1]  = shadow_tag[i];
          end
          shadow_count--;
        end
      end
      KIND_SEARCH: begin
        for (int i = 0; i < shadow_count; i++)
          if (shadow_tag[i] == tag) r.hit = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic script_row_t row(logic [KIND_BITS-1:0] op, logic [TAG_BITS-1:0] tag,
                                      logic [PRIO_BITS-1:0] prio, bit typed,
                                      queue_result_t want);
    script_row_t s;
    s.op = op;
    s.tag = tag;
    s.prio = prio;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // Present one item and hold it until accepted. Called right after a rising
  // edge; returns right after the edge that took the item.
  task automatic push_item(input logic [KIND_BITS-1:0] op, input logic [TAG_BITS-1:0] tag,
                           input logic [PRIO_BITS-1:0] prio, input bit typed,
                           input queue_result_t want);
    queue_result_t predicted;
    while (!steady && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= op;
    item_tag      <= tag;
    item_priority <= prio;
    do @(posedge clk); while (!in_ready);
    predicted = apply_queue_op(op, tag, prio);
    // where the table spells out the answer, hold the block to that instead
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Receiver: random back-pressure, quiet during the steady window.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 6);
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_result = {out_tag, out_priority, was_empty, found, dropped};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d arrived with nothing expected: tag=%h prio=%h empty=%b found=%b dropped=%b",
                   $realtime, results_seen, got_result.tag, got_result.prio,
                   got_result.empty, got_result.hit, got_result.drop);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.tag !== want_result.tag || got_result.prio !== want_result.prio ||
            got_result.empty !== want_result.empty || got_result.hit !== want_result.hit ||
            got_result.drop !== want_result.drop) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d mismatch: exp tag=%h prio=%h empty=%b found=%b dropped=%b, got tag=%h prio=%h empty=%b found=%b dropped=%b",
                     $realtime, results_seen,
                     want_result.tag, want_result.prio, want_result.empty,
                     want_result.hit, want_result.drop,
                     got_result.tag, got_result.prio, got_result.empty,
                     got_result.hit, got_result.drop);
        end
      end
    end
  end

  // Stimulus: directed script, then random traffic in segments that favor
  // filling, draining or a mix, so the queue goes full and empty many times.
  initial begin
    script_row_t          script [$];
    script_row_t          s;
    int                   mode;
    int                   pick;
    int                   ins_pct;
    int                   rem_pct;
    logic [KIND_BITS-1:0] op;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
    queue_result_t        empty_answer;
    queue_result_t        drop_answer;

    empty_answer       = '0;
    empty_answer.empty = 1'b1;
    drop_answer        = '0;
    drop_answer.drop   = 1'b1;

    // freshly reset: empty remove, search misses, no-op all zero
    script.push_back(row(KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, empty_answer));
    script.push_back(row(KIND_SEARCH, 32'h0000_0000, 16'h0000, 1'b1, '0));
    script.push_back(row(KIND_NOP,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, '0));
    script.push_back(row(KIND_SEARCH, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '0));
    // sixteen inserts fill the queue: extremes, and ties at top, middle, bottom
    script.push_back(row(KIND_INSERT, 32'hA000_0001, 16'h1000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h0000_0000, 16'h0000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'hA000_0004, 16'h8000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'hA000_0005, 16'h8000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'hA000_0006, 16'h8000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h5555_AAAA, 16'h0001, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'hAAAA_5555, 16'hFFFE, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'hA000_0009, 16'h0000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'hDEAD_BEEF, 16'h8000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h0000_0001, 16'h7FFF, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h0000_0002, 16'hFFFF, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h0000_0003, 16'h1000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h0000_0004, 16'h0000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h0000_0005, 16'h4000, 1'b0, '0));
    script.push_back(row(KIND_INSERT, 32'h0000_0006, 16'h4000, 1'b0, '0));
    // full now: the next insert bounces
    script.push_back(row(KIND_INSERT, 32'h1234_5678, 16'hFFFF, 1'b1, drop_answer));
    script.push_back(row(KIND_SEARCH, 32'hDEAD_BEEF, 16'h0000, 1'b0, '0));
    script.push_back(row(KIND_SEARCH, 32'h0000_0000, 16'h0000, 1'b0, '0));
    // head is the older of the two top-priority entries
    script.push_back(row(KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, '0));
    script.push_back(row(KIND_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, '0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      s = script[i];
      push_item(s.op, s.tag, s.prio, s.typed, s.want);
    end

    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) mode = $urandom_range(0, 2);
      steady <= (n >= 400 && n < 560);

      // hold off once until the queue of expected results runs dry
      if (n == 250) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end

      case (mode)
        0:       begin ins_pct = 75; rem_pct = 15; end  // filling
        1:       begin ins_pct = 20; rem_pct = 70; end  // draining
        default: begin ins_pct = 45; rem_pct = 40; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < ins_pct)                op = KIND_INSERT;
      else if (pick < ins_pct + rem_pct) op = KIND_REMOVE;
      else if (pick < 97)                op = KIND_SEARCH;
      else                               op = KIND_NOP;

      tag = $urandom;
      // mostly few distinct priorities so ties are common
      pick = $urandom_range(0, 9);
      if (pick < 5)       prio = PRIO_BITS'($urandom_range(0, 3)) << 14;
      else if (pick < 8)  prio = PRIO_BITS'($urandom);
      else if (pick == 8) prio = $urandom_range(0, 1) ? '1 : '0;
      else if (shadow_count > 0)
        prio = shadow_prio[$urandom_range(0, shadow_count - 1)];
      else
        prio = PRIO_BITS'($urandom);

      // searches hit a stored tag more often than not
      if (op == KIND_SEARCH && shadow_count > 0 && $urandom_range(0, 9) < 6)
        tag = shadow_tag[$urandom_range(0, shadow_count - 1)];

      push_item(op, tag, prio, 1'b0, '0);
    end

    in_valid <= 1'b0;
    steady   <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // then wait on to catch any stray result
    repeat (5) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond a full run with worst-case idling.
  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
